@@ rtl/media_sample_group_object_tagger_macros.svh @@
// Assertion macros for the sample tagger.
// Included by the top level only; no other dependencies.
`ifndef MEDIA_SAMPLE_GROUP_OBJECT_TAGGER_MACROS_SVH
`define MEDIA_SAMPLE_GROUP_OBJECT_TAGGER_MACROS_SVH
`define MSGOT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSGOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/msgot_pkg.sv @@
// Shared types and constants for the sample tagger.
// No dependencies.
package msgot_pkg;
    localparam int unsigned MAX_PAYLOAD_BYTES = 16777216;
    localparam int unsigned TS_W = 32;
    localparam int unsigned T_W = 64;
    localparam logic [19:0] US_PER_SECOND = 20'd1000000;

    typedef enum logic [3:0] {
        ST_EMITTED = 4'd0, ST_DROPPED = 4'd1, ST_COMMAND = 4'd2, ST_TS_MISMATCH = 4'd3,
        ST_INVALID = 4'd4, ST_DEC_OVF = 4'd5, ST_REGRESS = 4'd6, ST_UNREPR = 4'd7,
        ST_GRP_OVF = 4'd8, ST_OBJ_OVF = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE, FSM_DIV, FSM_MUL, FSM_NEXT, FSM_DONE
    } fsm_t;

    typedef enum logic [1:0] {
        C_IDLE, C_DIV, C_FRAC, C_MUL
    } conv_state_t;

    localparam logic [7:0] MARK_INDEP = 8'he0;
    localparam logic [7:0] MARK_DEP = 8'hc0;
    localparam logic [3:0] PROP_VIDEO = 4'd13;
    localparam logic [3:0] PROP_AUDIO = 4'd15;

    typedef struct packed {
        logic start;
        logic busy;
        logic ok;
    } conv_ctl_t;
endpackage

@@ rtl/msgot_conv.sv @@
// Bit-serial tick to microsecond converter: restoring division then shift-add scaling.
// Depends on msgot_pkg.
module msgot_conv (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [msgot_pkg::T_W-1:0]      ticks,
    input  logic [msgot_pkg::TS_W-1:0]     ts,
    output msgot_pkg::conv_ctl_t           ctl,
    output logic [msgot_pkg::T_W-1:0]      result
);
    localparam int unsigned CW = $clog2(msgot_pkg::T_W + 1);

    msgot_pkg::conv_state_t cst_reg, cst_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [msgot_pkg::T_W-1:0] q_reg, q_next;
    logic [msgot_pkg::TS_W:0] r_reg, r_next;
    logic [msgot_pkg::T_W-1:0] frac_reg, frac_next;
    logic [msgot_pkg::T_W+20:0] acc_reg, acc_next;
    logic [msgot_pkg::TS_W+20:0] num_reg, num_next;
    logic [msgot_pkg::TS_W:0] trial;
    logic [msgot_pkg::TS_W+20:0] ntrial;
    logic [msgot_pkg::T_W+20:0] sum;

    always_comb begin
        cst_next = cst_reg;
        unique case (cst_reg)
            msgot_pkg::C_IDLE: if (start) cst_next = msgot_pkg::C_DIV;
            msgot_pkg::C_DIV: if (cnt_reg == CW'(1)) cst_next = msgot_pkg::C_FRAC;
            msgot_pkg::C_FRAC: if (cnt_reg == CW'(1)) cst_next = msgot_pkg::C_MUL;
            msgot_pkg::C_MUL: if (cnt_reg == CW'(1)) cst_next = msgot_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        frac_next = frac_reg;
        acc_next = acc_reg;
        num_next = num_reg;
        trial = '0;
        ntrial = '0;
        sum = '0;
        unique case (cst_reg)
            msgot_pkg::C_IDLE: begin
                if (start) begin
                    q_next = ticks;
                    r_next = '0;
                    cnt_next = CW'(msgot_pkg::T_W);
                end
            end
            msgot_pkg::C_DIV: begin
                trial = {r_reg[msgot_pkg::TS_W-1:0], q_reg[msgot_pkg::T_W-1]};
                q_next = {q_reg[msgot_pkg::T_W-2:0], 1'b0};
                if (trial >= {1'b0, ts}) begin
                    r_next = trial - {1'b0, ts};
                    q_next[0] = 1'b1;
                end else begin
                    r_next = trial;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    num_next = (msgot_pkg::TS_W + 21)'(r_next[msgot_pkg::TS_W-1:0])
                        * (msgot_pkg::TS_W + 21)'(msgot_pkg::US_PER_SECOND);
                    frac_next = '0;
                    r_next = '0;
                    cnt_next = CW'(msgot_pkg::TS_W + 21);
                end
            end
            msgot_pkg::C_FRAC: begin
                ntrial = (msgot_pkg::TS_W + 21)'({r_reg[msgot_pkg::TS_W-1:0],
                                                  num_reg[msgot_pkg::TS_W+20]});
                num_next = {num_reg[msgot_pkg::TS_W+19:0], 1'b0};
                frac_next = {frac_reg[msgot_pkg::T_W-2:0], 1'b0};
                if (ntrial >= (msgot_pkg::TS_W + 21)'(ts)) begin
                    r_next = (msgot_pkg::TS_W+1)'(ntrial - (msgot_pkg::TS_W + 21)'(ts));
                    frac_next[0] = 1'b1;
                end else begin
                    r_next = ntrial[msgot_pkg::TS_W:0];
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    acc_next = '0;
                    cnt_next = CW'(20);
                end
            end
            msgot_pkg::C_MUL: begin
                sum = {acc_reg[msgot_pkg::T_W+19:0], 1'b0};
                if (msgot_pkg::US_PER_SECOND[cnt_reg[4:0] - 5'd1]) begin
                    sum = sum + (msgot_pkg::T_W + 21)'(q_reg);
                end
                acc_next = sum;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    acc_next = sum + (msgot_pkg::T_W + 21)'(frac_reg);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cst_reg <= msgot_pkg::C_IDLE;
            cnt_reg <= '0;
        end else begin
            cst_reg <= cst_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        frac_reg <= frac_next;
        acc_reg <= acc_next;
        num_reg <= num_next;
    end

    assign ctl.start = start;
    assign ctl.busy = (cst_reg != msgot_pkg::C_IDLE);
    assign ctl.ok = (acc_reg[msgot_pkg::T_W+20:msgot_pkg::T_W] == '0);
    assign result = acc_reg[msgot_pkg::T_W-1:0];
endmodule

@@ rtl/media_sample_group_object_tagger.sv @@
// Top level of the media sample group/object tagger.
// Depends on msgot_pkg, msgot_conv and the assertion macro header.
//
// Usage: each request on the s_ channel carries one coded sample or a
// random-access command; each produces exactly one result on the m_ channel
// with a status code and, when emitted, group/object numbers and times in us.
// Configuration (is_video at 0x0, track_timescale at 0x4) goes through the
// APB port; the user must write it only while the block is idle, which the
// block itself does not enforce. For commands and samples rejected by the
// early checks the result is valid in the cycle after the accepting edge. A
// sample that passes the checks runs three bit-serial converters side by
// side, each 64 division steps, 53 fraction steps and 20 scaling steps;
// its result is registered through the NEXT and DONE states once all three
// converters are idle. One request is in flight at a time; the next is
// taken in the cycle after the previous result has been taken.
// A stall on m_ready holds the result and blocks new requests.
// Reset clears the timeline state and the counters, and sets the registers to
// video with a timescale of 90000.
module media_sample_group_object_tagger #(
    parameter int unsigned MAX_PAYLOAD_BYTES = msgot_pkg::MAX_PAYLOAD_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [63:0] s_decode_time,
    input  logic signed [63:0] s_presentation_time,
    input  logic [63:0] s_duration,
    input  logic [31:0] s_byte_count,
    input  logic        s_independent,
    input  logic [31:0] s_sample_timescale,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [63:0] m_group_number,
    output logic [63:0] m_object_number,
    output logic [63:0] m_start_time_us,
    output logic [63:0] m_presentation_time_us,
    output logic [63:0] m_duration_us,
    output logic        m_is_keyframe,
    output logic        m_sap_kind,
    output logic [7:0]  m_frame_marking,
    output logic [3:0]  m_extradata_property_kind
);
`include "media_sample_group_object_tagger_macros.svh"

    logic is_video_reg;
    logic [31:0] ts_reg;
    logic [63:0] ndt_reg, grp_reg, obj_reg;
    logic have_reg, await_reg, started_reg;
    msgot_pkg::fsm_t st_reg, st_next;
    logic [63:0] dts_reg, pts_reg, dur_reg;
    logic indep_reg, wait_reg, bad_reg;
    logic [63:0] pgrp_reg, pobj_reg;
    logic [63:0] us_reg [3];
    logic m_valid_reg;
    msgot_pkg::status_t status_reg;
    logic conv_start;
    logic [63:0] us_dts, us_pts, us_dur;
    msgot_pkg::conv_ctl_t ctl_dts, ctl_pts, ctl_dur;
    logic conv_busy, conv_ok;

    logic wr;
    logic accept;
    logic [64:0] end_sum;
    logic chk_wait, new_grp;
    msgot_pkg::status_t early_st;
    logic early;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[2])
            1'b0: prdata = {31'd0, is_video_reg};
            default: prdata = ts_reg;
        endcase
    end

    assign s_ready = (st_reg == msgot_pkg::FSM_IDLE) && !m_valid_reg;
    assign accept = s_valid && s_ready;
    assign end_sum = {1'b0, s_decode_time} + {1'b0, s_duration};

    always_comb begin
        early = 1'b1;
        early_st = msgot_pkg::ST_EMITTED;
        chk_wait = await_reg || (have_reg && is_video_reg && s_decode_time != ndt_reg);
        new_grp = !started_reg || !is_video_reg || s_independent;
        priority if (s_command) early_st = msgot_pkg::ST_COMMAND;
        else if (ts_reg == '0 || s_sample_timescale != ts_reg)
            early_st = msgot_pkg::ST_TS_MISMATCH;
        else if (s_presentation_time[63] || s_duration == '0 || s_byte_count == '0
                 || s_byte_count > MAX_PAYLOAD_BYTES)
            early_st = msgot_pkg::ST_INVALID;
        else if (end_sum[64]) early_st = msgot_pkg::ST_DEC_OVF;
        else if (have_reg && s_decode_time < ndt_reg) early_st = msgot_pkg::ST_REGRESS;
        else if (is_video_reg && chk_wait && !s_independent) early_st = msgot_pkg::ST_DROPPED;
        else if (new_grp && started_reg && grp_reg == '1) early_st = msgot_pkg::ST_GRP_OVF;
        else early = 1'b0;
    end

    assign conv_busy = ctl_dts.busy || ctl_pts.busy || ctl_dur.busy;
    assign conv_ok = ctl_dts.ok && ctl_pts.ok && ctl_dur.ok;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            msgot_pkg::FSM_IDLE: if (accept && !early) st_next = msgot_pkg::FSM_DIV;
            msgot_pkg::FSM_DIV: st_next = msgot_pkg::FSM_MUL;
            msgot_pkg::FSM_MUL: if (!conv_busy) st_next = msgot_pkg::FSM_NEXT;
            msgot_pkg::FSM_NEXT: st_next = msgot_pkg::FSM_DONE;
            msgot_pkg::FSM_DONE: st_next = msgot_pkg::FSM_IDLE;
            default: st_next = msgot_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        conv_start = (st_reg == msgot_pkg::FSM_DIV);
    end

    msgot_conv u_conv_dts (
        .aclk(aclk), .aresetn(aresetn), .start(conv_start), .ticks(dts_reg),
        .ts(ts_reg), .ctl(ctl_dts), .result(us_dts)
    );

    msgot_conv u_conv_pts (
        .aclk(aclk), .aresetn(aresetn), .start(conv_start), .ticks(pts_reg),
        .ts(ts_reg), .ctl(ctl_pts), .result(us_pts)
    );

    msgot_conv u_conv_dur (
        .aclk(aclk), .aresetn(aresetn), .start(conv_start), .ticks(dur_reg),
        .ts(ts_reg), .ctl(ctl_dur), .result(us_dur)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_video_reg <= 1'b1;
            ts_reg <= 32'd90000;
            ndt_reg <= '0;
            grp_reg <= '0;
            obj_reg <= '0;
            have_reg <= 1'b0;
            await_reg <= 1'b0;
            started_reg <= 1'b0;
            st_reg <= msgot_pkg::FSM_IDLE;
            m_valid_reg <= 1'b0;
            bad_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (wr) begin
                if (paddr[2] == 1'b0) is_video_reg <= pwdata[0];
                else ts_reg <= pwdata;
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (accept) begin
                dts_reg <= s_decode_time;
                pts_reg <= s_presentation_time;
                dur_reg <= s_duration;
                indep_reg <= s_independent;
                bad_reg <= 1'b0;
                wait_reg <= new_grp ? 1'b0 : chk_wait;
                pgrp_reg <= (new_grp && started_reg) ? grp_reg + 64'd1 : grp_reg;
                pobj_reg <= new_grp ? 64'd0 : obj_reg;
                if (early) begin
                    m_valid_reg <= 1'b1;
                    status_reg <= early_st;
                    if (s_command) await_reg <= 1'b1;
                    if (early_st == msgot_pkg::ST_DROPPED) begin
                        ndt_reg <= end_sum[63:0];
                        have_reg <= 1'b1;
                        await_reg <= 1'b1;
                    end
                end
            end
            if (st_reg == msgot_pkg::FSM_NEXT) begin
                us_reg[0] <= us_dts;
                us_reg[1] <= us_pts;
                us_reg[2] <= us_dur;
                if (!conv_ok) bad_reg <= 1'b1;
            end
            if (st_reg == msgot_pkg::FSM_DONE) begin
                m_valid_reg <= 1'b1;
                if (bad_reg) status_reg <= msgot_pkg::ST_UNREPR;
                else if (pobj_reg == '1) status_reg <= msgot_pkg::ST_OBJ_OVF;
                else begin
                    status_reg <= msgot_pkg::ST_EMITTED;
                    ndt_reg <= dts_reg + dur_reg;
                    have_reg <= 1'b1;
                    await_reg <= wait_reg;
                    started_reg <= 1'b1;
                    grp_reg <= pgrp_reg;
                    obj_reg <= pobj_reg + 64'd1;
                end
            end
        end
    end

    logic emit;
    assign emit = (status_reg == msgot_pkg::ST_EMITTED);
    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_group_number = emit ? pgrp_reg : '0;
    assign m_object_number = emit ? pobj_reg : '0;
    assign m_start_time_us = emit ? us_reg[0] : '0;
    assign m_presentation_time_us = emit ? us_reg[1] : '0;
    assign m_duration_us = emit ? us_reg[2] : '0;
    assign m_is_keyframe = emit && is_video_reg && indep_reg;
    assign m_sap_kind = emit && indep_reg;
    assign m_frame_marking = !emit || !is_video_reg ? 8'd0
                           : (indep_reg ? msgot_pkg::MARK_INDEP : msgot_pkg::MARK_DEP);
    assign m_extradata_property_kind = is_video_reg ? msgot_pkg::PROP_VIDEO
                                                    : msgot_pkg::PROP_AUDIO;

    `MSGOT_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, st_reg != msgot_pkg::FSM_IDLE, !s_ready)
    `MSGOT_ASSERT_NEXT(a_done_valid, aclk, aresetn, st_reg == msgot_pkg::FSM_DONE, m_valid)
    `MSGOT_ASSERT_IMPL(a_emit_started, aclk, aresetn, m_valid && emit, started_reg)
endmodule

@@ dv/tagger_checker.sv @@
// Checker for the media sample group/object tagger: watches both channels,
// predicts each result from its own copy of the block state and compares.
// Depends on msgot_pkg for status codes and marking constants.
`timescale 1ns / 1ps
module tagger_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_command,
    input  logic [63:0] s_decode_time,
    input  logic [63:0] s_presentation_time,
    input  logic [63:0] s_duration,
    input  logic [31:0] s_byte_count,
    input  logic        s_independent,
    input  logic [31:0] s_sample_timescale,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_status,
    input  logic [63:0] m_group_number,
    input  logic [63:0] m_object_number,
    input  logic [63:0] m_start_time_us,
    input  logic [63:0] m_presentation_time_us,
    input  logic [63:0] m_duration_us,
    input  logic        m_is_keyframe,
    input  logic        m_sap_kind,
    input  logic [7:0]  m_frame_marking,
    input  logic [3:0]  m_extradata_property_kind,
    output int          fail_count,
    output int          pending_count,
    output int          emitted_count
);
    localparam logic [2:0] ADDR_IS_VIDEO = 3'd0;
    localparam logic [2:0] ADDR_TIMESCALE = 3'd4;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] grp;
        logic [63:0] obj;
        logic [63:0] start_us;
        logic [63:0] pts_us;
        logic [63:0] dur_us;
        logic        key;
        logic        sap;
        logic [7:0]  mark;
        logic [3:0]  prop;
    } tag_result_t;

    tag_result_t expected_tags[$];

    logic        video_q;
    logic [31:0] timescale_q;
    logic [63:0] next_dts;
    logic        have_next;
    logic        awaiting_key;
    logic        started;
    logic [63:0] group_q;
    logic [63:0] object_q;

    function automatic logic ticks_to_us(input logic [63:0] ticks, input logic [31:0] ts,
                                         output logic [63:0] us);
        logic [63:0] q, r, whole;
        logic [127:0] frac;
        logic [64:0] total;
        us = '0;
        if (ts == 0) return 1'b0;
        q = ticks / ts;
        r = ticks % ts;
        if (q > 64'hffff_ffff_ffff_ffff / 64'd1000000) return 1'b0;
        whole = q * 64'd1000000;
        frac = ({64'd0, r} * 128'd1000000) / ts;
        total = {1'b0, whole} + {1'b0, frac[63:0]};
        if (total[64]) return 1'b0;
        us = total[63:0];
        return 1'b1;
    endfunction

    task automatic tag_sample(output tag_result_t res);
        logic wait_key, new_grp, ok;
        logic [63:0] g, o, us0, us1, us2;
        res = '0;
        res.prop = video_q ? msgot_pkg::PROP_VIDEO : msgot_pkg::PROP_AUDIO;
        if (s_command) begin
            awaiting_key = 1'b1;
            res.status = msgot_pkg::ST_COMMAND;
            return;
        end
        if (timescale_q == 0 || s_sample_timescale != timescale_q) begin
            res.status = msgot_pkg::ST_TS_MISMATCH;
            return;
        end
        if (s_presentation_time[63] || s_duration == 0 || s_byte_count == 0 ||
            s_byte_count > msgot_pkg::MAX_PAYLOAD_BYTES) begin
            res.status = msgot_pkg::ST_INVALID;
            return;
        end
        if (s_duration > ~s_decode_time) begin
            res.status = msgot_pkg::ST_DEC_OVF;
            return;
        end
        wait_key = awaiting_key;
        if (have_next) begin
            if (s_decode_time < next_dts) begin
                res.status = msgot_pkg::ST_REGRESS;
                return;
            end
            if (video_q && s_decode_time != next_dts) wait_key = 1'b1;
        end
        if (video_q && wait_key && !s_independent) begin
            next_dts = s_decode_time + s_duration;
            have_next = 1'b1;
            awaiting_key = 1'b1;
            res.status = msgot_pkg::ST_DROPPED;
            return;
        end
        new_grp = !started || !video_q || s_independent;
        g = group_q;
        o = object_q;
        if (new_grp) begin
            if (started) begin
                if (&g) begin
                    res.status = msgot_pkg::ST_GRP_OVF;
                    return;
                end
                g++;
            end
            o = '0;
            wait_key = 1'b0;
        end
        ok = ticks_to_us(s_decode_time, timescale_q, us0);
        ok = ok && ticks_to_us(s_presentation_time, timescale_q, us1);
        ok = ok && ticks_to_us(s_duration, timescale_q, us2);
        if (!ok) begin
            res.status = msgot_pkg::ST_UNREPR;
            return;
        end
        if (&o) begin
            res.status = msgot_pkg::ST_OBJ_OVF;
            return;
        end
        next_dts = s_decode_time + s_duration;
        have_next = 1'b1;
        awaiting_key = wait_key;
        started = 1'b1;
        group_q = g;
        object_q = o + 64'd1;
        res.status = msgot_pkg::ST_EMITTED;
        res.grp = g;
        res.obj = o;
        res.start_us = us0;
        res.pts_us = us1;
        res.dur_us = us2;
        res.key = video_q && s_independent;
        res.sap = s_independent;
        res.mark = video_q ? (s_independent ? msgot_pkg::MARK_INDEP : msgot_pkg::MARK_DEP)
                           : 8'd0;
    endtask

    always @(posedge aclk) begin
        tag_result_t want, got;
        if (!aresetn) begin
            video_q = 1'b1;
            timescale_q = 32'd90000;
            next_dts = '0;
            have_next = 1'b0;
            awaiting_key = 1'b0;
            started = 1'b0;
            group_q = '0;
            object_q = '0;
            expected_tags.delete();
            fail_count = 0;
            emitted_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == ADDR_IS_VIDEO) video_q = cfg_data[0];
                else if (cfg_addr == ADDR_TIMESCALE) timescale_q = cfg_data;
            end
            if (m_valid && m_ready) begin
                got = '{m_status, m_group_number, m_object_number, m_start_time_us,
                        m_presentation_time_us, m_duration_us, m_is_keyframe,
                        m_sap_kind, m_frame_marking, m_extradata_property_kind};
                if (expected_tags.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result status %0d", m_status);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_tags.pop_front();
                    if (got != want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        fail_count = fail_count + 1;
                    end
                    if (want.status == msgot_pkg::ST_EMITTED) emitted_count = emitted_count + 1;
                end
            end
            if (s_valid && s_ready) begin
                tag_sample(want);
                expected_tags.insert(expected_tags.size(), want);
            end
        end
        pending_count = expected_tags.size();
    end
endmodule

@@ dv/tb_top.sv @@
// Testbench top for the media sample group/object tagger: drives requests,
// configuration and a stalling receiver, and gives the verdict.
// Depends on tagger_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
    localparam logic [2:0] ADDR_IS_VIDEO = 3'd0;
    localparam logic [2:0] ADDR_TIMESCALE = 3'd4;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready;
    logic s_command = 1'b0;
    logic [63:0] s_decode_time = '0, s_presentation_time = '0, s_duration = '0;
    logic [31:0] s_byte_count = '0, s_sample_timescale = '0;
    logic s_independent = 1'b0;
    logic m_valid, m_ready = 1'b0;
    logic [3:0] m_status, m_extradata_property_kind;
    logic [63:0] m_group_number, m_object_number, m_start_time_us;
    logic [63:0] m_presentation_time_us, m_duration_us;
    logic m_is_keyframe, m_sap_kind;
    logic [7:0] m_frame_marking;
    int fail_count, pending_count, emitted_count;
    int sent_count = 0;
    logic [31:0] cur_ts = 32'd90000;
    logic [63:0] cur_dts = '0;

    always #1 aclk = ~aclk;

    media_sample_group_object_tagger DUT (.*);

    tagger_checker checker_i (
        .aclk, .aresetn, .cfg_we(psel && penable && pwrite && pready),
        .cfg_addr(paddr), .cfg_data(pwdata),
        .s_valid, .s_ready, .s_command, .s_decode_time, .s_presentation_time,
        .s_duration, .s_byte_count, .s_independent, .s_sample_timescale,
        .m_valid, .m_ready, .m_status, .m_group_number, .m_object_number,
        .m_start_time_us, .m_presentation_time_us, .m_duration_us,
        .m_is_keyframe, .m_sap_kind, .m_frame_marking, .m_extradata_property_kind,
        .fail_count, .pending_count, .emitted_count);

    initial begin
        int mode;
        forever begin
            @(negedge aclk);
            mode = $urandom_range(0, 9);
            if (mode < 3) m_ready <= 1'b1;
            else if (mode < 8) m_ready <= $urandom_range(0, 3) != 0;
            else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic configure(input logic video, input logic [31:0] ts);
        drain();
        reg_write(ADDR_IS_VIDEO, {31'd0, video});
        reg_write(ADDR_TIMESCALE, ts);
        cur_ts = ts;
    endtask

    task automatic send_request(input logic cmd, input logic [63:0] dts,
                                input logic [63:0] pts, input logic [63:0] dur,
                                input logic [31:0] bytes, input logic indep,
                                input logic [31:0] sts);
        s_valid <= 1'b1;
        s_command <= cmd; s_decode_time <= dts; s_presentation_time <= pts;
        s_duration <= dur; s_byte_count <= bytes; s_independent <= indep;
        s_sample_timescale <= sts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic send_sample(input logic [63:0] dur, input logic indep);
        send_request(1'b0, cur_dts, cur_dts + $urandom_range(0, 3000), dur,
                     $urandom_range(1, 200000), indep, cur_ts);
        cur_dts = cur_dts + dur;
    endtask

    task automatic send_random();
        int kind;
        logic [63:0] dts, pts, dur;
        logic [31:0] bytes, sts;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            dur = $urandom_range(1, 6000);
            if ($urandom_range(0, 19) == 0) cur_dts = cur_dts + $urandom_range(1, 9000);
            send_sample(dur, $urandom_range(0, 4) == 0);
        end else if (kind < 80) begin
            send_request(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, $urandom, $urandom_range(0, 1), $urandom);
        end else begin
            dts = {$urandom, $urandom};
            pts = {$urandom, $urandom};
            dur = {$urandom, $urandom};
            bytes = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 16777217);
            sts = $urandom_range(0, 3) ? cur_ts : $urandom;
            if ($urandom_range(0, 1)) begin
                dts = cur_dts + $urandom_range(0, 5);
                dur = $urandom_range(0, 3000);
                pts = {1'b0, pts[62:0]};
            end
            send_request(1'b0, dts, pts, dur, bytes, $urandom_range(0, 1), sts);
            if (dur != 0 && dur <= ~dts) cur_dts = dts + dur;
        end
    endtask

    initial begin
        int burst;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests on the reset configuration.
        send_sample(64'd3000, 1'b1);
        send_sample(64'd3000, 1'b0);
        send_request(1'b0, cur_dts, 64'd0, 64'd3000, 32'd100, 1'b0, 32'd1);
        send_request(1'b0, cur_dts, 64'h8000_0000_0000_0000, 64'd1, 32'd1, 1'b1, cur_ts);
        send_request(1'b0, cur_dts, 64'd0, 64'd0, 32'd1, 1'b1, cur_ts);
        send_request(1'b0, cur_dts, 64'd0, 64'd1, 32'd0, 1'b1, cur_ts);
        send_request(1'b0, cur_dts, 64'd0, 64'd1, 32'd16777217, 1'b1, cur_ts);
        send_request(1'b0, cur_dts, 64'd0, 64'd1, 32'hffff_ffff, 1'b1, cur_ts);
        send_request(1'b0, cur_dts, 64'd0, 64'd1, 32'd16777216, 1'b0, cur_ts);
        cur_dts = cur_dts + 1;
        send_request(1'b0, 64'hffff_ffff_ffff_fff0, 64'd0, 64'hff, 32'd1, 1'b1, cur_ts);
        send_request(1'b0, 64'd0, 64'd0, 64'd1, 32'd1, 1'b1, cur_ts);
        cur_dts = cur_dts + 500;
        send_sample(64'd3000, 1'b0);
        send_sample(64'd3000, 1'b1);
        send_request(1'b1, '0, '0, '0, '0, 1'b0, '0);
        send_sample(64'd3000, 1'b0);
        send_sample(64'd3000, 1'b1);
        send_request(1'b0, cur_dts, 64'h7fff_ffff_ffff_ffff, 64'd10, 32'd1, 1'b0, cur_ts);
        cur_dts = cur_dts + 10;

        configure(1'b0, 32'd1);
        send_request(1'b0, cur_dts, 64'd5, 64'd1, 32'd1, 1'b0, 32'd1);
        send_request(1'b0, 64'hffff_ffff_ffff_0000, 64'd5, 64'd1, 32'd1, 1'b0, 32'd1);
        cur_dts = 64'hffff_ffff_ffff_0001;
        configure(1'b1, 32'hffff_ffff);
        send_request(1'b0, cur_dts, 64'h7fff_ffff_ffff_ffff, 64'hfffe, 32'd1, 1'b1,
                     32'hffff_ffff);
        configure(1'b1, 32'd0);
        send_request(1'b0, '0, '0, 64'd1, 32'd1, 1'b1, 32'd0);
        // Wait for every expected result before continuing.
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: configure(1'b1, 32'd90000);
                1: configure(1'b0, 32'd48000);
                2: configure(1'b1, 32'd1000000);
                3: configure(1'b0, 32'd1);
                default: configure(1'b1, 32'hffff_fff0 | $urandom_range(0, 15));
            endcase
            cur_dts = {$urandom_range(0, 3), $urandom};
            for (int n = 0; n < 150; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 150; b++, n++) send_random();
                if ($urandom_range(0, 2) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(negedge aclk);
                end
            end
        end

        drain();
        $display("sent %0d requests over nine track setups, %0d samples emitted",
                 sent_count, emitted_count);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
